// ===== sv/sb2d_pkg.sv =====
// Package for the signed binary to decimal ASCII converter.
// Character codes, the converter-to-emitter status word and digit sizing.
// No dependencies.
package sb2d_pkg;

    localparam int DIGIT_W = 4;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

    // status word from the converter to the character emitter
    typedef struct packed {
        logic valid;     // BCD result held and waiting
        logic negative;  // input was below zero
    } t_conv_status;

    // decimal digits needed for the magnitude 2^(bits-1); log10(2) ~ 0.30103
    function automatic int digits_for(input int bits);
        return ((bits - 1) * 30103) / 100000 + 1;
    endfunction

endpackage

// ===== sv/sb2d_if.sv =====
// Valid/ready channel interfaces for the converter's input and output words.
// Depends on nothing; used by the top level and its submodules.
interface sb2d_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sb2d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ===== sv/sb2d_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on sb2d_pkg and sb2d_in_if; hands its result to sb2d_emit.
module sb2d_dabble
    import sb2d_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sb2d_in_if.sink                     i_in,
    output t_conv_status                o_status,
    output logic [digits_for(VALUE_BITS)*DIGIT_W-1:0] o_bcd,
    input  logic                        i_take
);

    localparam int NDIG  = digits_for(VALUE_BITS);
    localparam int BCD_W = NDIG * DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state                r_state;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [CNT_W-1:0]      r_cnt;

    logic [VALUE_BITS-1:0] n_raw;
    logic [VALUE_BITS-1:0] n_mag;
    logic [BCD_W-1:0]      n_adj;

    assign n_raw = i_in.value;
    assign n_mag = n_raw[VALUE_BITS-1] ? (VALUE_BITS'(0) - n_raw) : n_raw;

    // add 3 to every digit at 5 or above before the shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                n_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                n_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_status.valid    = (r_state == S_DONE);
    assign o_status.negative = r_neg;
    assign o_bcd             = r_bcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_neg   <= n_raw[VALUE_BITS-1];
                        r_bin   <= n_mag;
                        r_bcd   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_bcd <= {n_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                    r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_SHIFT && r_cnt == '0 && r_bcd == '0))
        else $error("conversion did not start from a cleared accumulator");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_cnt <= CNT_W'(VALUE_BITS - 1)))
        else $error("bit counter ran past the word width");

    a_take_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_take) |=> (r_state == S_DONE && $stable(r_bcd)))
        else $error("BCD result changed before the emitter took it");

    a_top_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_bcd[BCD_W-1 -: DIGIT_W] <= DIGIT_NINE))
        else $error("leading BCD digit out of range");

endmodule

// ===== sv/sb2d_emit.sv =====
// Character emitter: drops leading zeros one digit per cycle, then sends the
// sign and the digits one word per cycle while the sink accepts them. Depends on sb2d_pkg and sb2d_out_if.
module sb2d_emit
    import sb2d_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_conv_status                i_status,
    input  logic [digits_for(VALUE_BITS)*DIGIT_W-1:0] i_bcd,
    output logic                        o_take,
    sb2d_out_if.source                  o_out
);

    localparam int NDIG   = digits_for(VALUE_BITS);
    localparam int BCD_W  = NDIG * DIGIT_W;
    localparam int LEFT_W = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STRIP,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [BCD_W-1:0]   r_digits;
    logic [LEFT_W-1:0]  r_left;
    logic               r_sign;
    logic               r_out_valid;
    logic [7:0]         r_char;
    logic               r_last;

    logic [DIGIT_W-1:0] n_top;
    logic               n_free;
    logic               n_send;

    assign n_top  = r_digits[BCD_W-1 -: DIGIT_W];
    assign n_free = !r_out_valid || o_out.ready;
    assign n_send = (r_state == S_EMIT) && n_free;
    assign o_take = (r_state == S_IDLE) && i_status.valid;

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.last_char = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && !n_send) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_status.valid) begin
                        r_digits <= i_bcd;
                        r_sign   <= i_status.negative;
                        r_left   <= LEFT_W'(NDIG);
                        r_state  <= S_STRIP;
                    end
                end
                S_STRIP: begin
                    // keep at least one digit so zero prints as '0'
                    if (n_top == '0 && r_left != LEFT_W'(1)) begin
                        r_digits <= {r_digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        r_left   <= r_left - LEFT_W'(1);
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (n_free) begin
                        r_out_valid <= 1'b1;
                        if (r_sign) begin
                            r_char <= CHAR_MINUS;
                            r_last <= 1'b0;
                            r_sign <= 1'b0;
                        end else begin
                            r_char   <= CHAR_ZERO + {4'b0, n_top};
                            r_last   <= (r_left == LEFT_W'(1));
                            r_digits <= {r_digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                            r_left   <= r_left - LEFT_W'(1);
                            if (r_left == LEFT_W'(1)) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STRIP || r_state == S_EMIT) |-> (r_left != '0))
        else $error("digit count reached zero inside a run");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_char == CHAR_MINUS) |-> !r_last)
        else $error("sign word flagged as last");

    a_digit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_char != CHAR_MINUS) |->
            (r_char >= CHAR_ZERO && r_char <= CHAR_ZERO + 8'd9))
        else $error("digit word outside '0'..'9'");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_free && !r_sign && r_left == LEFT_W'(1)) |=>
            (r_state == S_IDLE && r_last))
        else $error("final digit not flagged as last");

endmodule

// ===== sv/signed_binary_to_decimal_ascii.sv =====
// Signed binary to decimal ASCII: bit-serial BCD conversion, then one word per char.
// The converter accepts a new number once the emitter has taken its last result, so
// the shift-and-add-3 loop, one bit per cycle, works on the next number's bits while
// the emitter sends the previous number's characters.
// Reset (synchronous, active low) returns both controllers to idle, no word pending.
// Depends on sb2d_pkg, sb2d_if, sb2d_dabble and sb2d_emit.
module signed_binary_to_decimal_ascii
    import sb2d_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sb2d_in_if.sink     i_in,
    sb2d_out_if.source  o_out
);

    localparam int BCD_W = digits_for(VALUE_BITS) * DIGIT_W;

    t_conv_status     w_status;
    logic [BCD_W-1:0] w_bcd;
    logic             w_take;

    sb2d_dabble #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_status (w_status),
        .o_bcd    (w_bcd),
        .i_take   (w_take)
    );

    sb2d_emit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .i_bcd    (w_bcd),
        .o_take   (w_take),
        .o_out    (o_out)
    );

endmodule
